>>> sv/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SENS        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REF_TEMP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_SLOPE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS        = 3'd6;

    localparam int LOW_TEMP_LIMIT = 2000;
    localparam int BIAS_RESET     = 700;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temp;
    } sample_t;

    typedef struct packed {
        logic signed [18:0] temp_centideg;
        logic signed [31:0] pressure_out;
    } result_t;

endpackage

>>> sv/pressure_sensor_compensation_core.sv
`timescale 1ns / 1ps

// Second-order compensation of one raw pressure/temperature conversion pair into
// a temperature in 0.01 degC and a pressure (x100) plus a programmable bias.
// The datapath is a nine-stage pipeline: a sample beat may be taken every cycle
// while result_ready stays high. Each stage carries its own valid bit, so a low
// result_ready holds only the occupied stages and bubbles still close up;
// sample_ready drops once every stage is full. The widest arithmetic, the 24 x 38
// bit pressure product, is split into two partial products in one stage and summed
// in the next. Calibration words and the bias are to be written through the cfg
// port only while no sample is in flight; the block itself does not enforce this.
// An index above six is ignored.
module pressure_sensor_compensation_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  psc_pkg::sample_t                 sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output psc_pkg::result_t                 result,
    input  logic                             cfg_write,
    input  logic [psc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import psc_pkg::*;

    localparam int NS = 9;

    logic [15:0]        sens_coeff_reg;
    logic [15:0]        offset_coeff_reg;
    logic [15:0]        sens_temp_coeff_reg;
    logic [15:0]        offset_temp_coeff_reg;
    logic [15:0]        ref_temp_coeff_reg;
    logic [15:0]        temp_slope_coeff_reg;
    logic signed [15:0] pressure_bias_reg;

    logic [NS-1:0] en;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;

    logic [23:0]        s1_d1_reg;
    logic signed [24:0] s1_dt_reg;
    logic signed [24:0] s1_dt_next;

    logic [23:0]        s2_d1_reg;
    logic signed [41:0] s2_p6_reg;
    logic signed [41:0] s2_p4_reg;
    logic signed [41:0] s2_p3_reg;
    logic [47:0]        s2_dd_reg;
    logic signed [41:0] s2_p6_next;
    logic signed [41:0] s2_p4_next;
    logic signed [41:0] s2_p3_next;
    logic [47:0]        s2_dd_next;

    logic [23:0]        s3_d1_reg;
    logic signed [18:0] s3_tsh_reg;
    logic signed [18:0] s3_temp_reg;
    logic signed [39:0] s3_off_reg;
    logic signed [37:0] s3_sens_reg;
    logic               s3_low_reg;
    logic [16:0]        s3_tcorr_reg;
    logic signed [18:0] s3_tsh_next;
    logic signed [18:0] s3_temp_next;
    logic signed [39:0] s3_off_next;
    logic signed [37:0] s3_sens_next;
    logic [51:0]        dd11;

    logic [23:0]        s4_d1_reg;
    logic signed [18:0] s4_temp_reg;
    logic signed [39:0] s4_off_reg;
    logic signed [37:0] s4_sens_reg;
    logic               s4_low_reg;
    logic [16:0]        s4_tcorr_reg;
    logic [34:0]        s4_sq_reg;
    logic [34:0]        s4_sq_next;

    logic [23:0]        s5_d1_reg;
    logic signed [18:0] s5_temp_reg;
    logic signed [39:0] s5_off_reg;
    logic signed [37:0] s5_sens_reg;
    logic signed [18:0] s5_temp_next;
    logic signed [39:0] s5_off_next;
    logic signed [37:0] s5_sens_next;
    logic [39:0]        sq31;
    logic [40:0]        sq63;

    logic signed [18:0] s6_temp_reg;
    logic signed [39:0] s6_off_reg;
    logic [42:0]        s6_ml_reg;
    logic signed [43:0] s6_mh_reg;
    logic [42:0]        s6_ml_next;
    logic signed [43:0] s6_mh_next;

    logic signed [18:0] s7_temp_reg;
    logic signed [39:0] s7_off_reg;
    logic signed [63:0] s7_prod_reg;
    logic signed [63:0] s7_prod_next;

    logic signed [18:0] s8_temp_reg;
    logic signed [43:0] s8_diff_reg;
    logic signed [43:0] s8_diff_next;

    logic signed [33:0] pres_wide;
    result_t            result_reg;
    result_t            result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_coeff_reg        <= '0;
            offset_coeff_reg      <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temp_coeff_reg    <= '0;
            temp_slope_coeff_reg  <= '0;
            pressure_bias_reg     <= 16'(BIAS_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SENS:        sens_coeff_reg        <= cfg_data;
                CFG_OFFSET:      offset_coeff_reg      <= cfg_data;
                CFG_SENS_TEMP:   sens_temp_coeff_reg   <= cfg_data;
                CFG_OFFSET_TEMP: offset_temp_coeff_reg <= cfg_data;
                CFG_REF_TEMP:    ref_temp_coeff_reg    <= cfg_data;
                CFG_TEMP_SLOPE:  temp_slope_coeff_reg  <= cfg_data;
                CFG_BIAS:        pressure_bias_reg     <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || result_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? sample_valid : v_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign sample_ready = en[0];
    assign result_valid = v_reg[NS-1];
    assign result       = result_reg;

    assign s1_dt_next = $signed({1'b0, sample.raw_temp}) -
                        $signed({1'b0, ref_temp_coeff_reg, 8'd0});

    assign s2_p6_next = s1_dt_reg * $signed({1'b0, temp_slope_coeff_reg});
    assign s2_p4_next = s1_dt_reg * $signed({1'b0, offset_temp_coeff_reg});
    assign s2_p3_next = s1_dt_reg * $signed({1'b0, sens_temp_coeff_reg});
    assign s2_dd_next = 48'(s1_dt_reg) * 48'(s1_dt_reg);

    assign s3_tsh_next  = $signed(s2_p6_reg[41:23]);
    assign s3_temp_next = s3_tsh_next + 19'(LOW_TEMP_LIMIT);
    assign s3_off_next  = $signed({7'd0, offset_coeff_reg, 17'd0}) +
                          40'($signed(s2_p4_reg[41:6]));
    assign s3_sens_next = $signed({6'd0, sens_coeff_reg, 16'd0}) +
                          38'($signed(s2_p3_reg[41:7]));
    assign dd11 = {1'b0, s2_dd_reg, 3'd0} + {3'd0, s2_dd_reg, 1'b0} + {4'd0, s2_dd_reg};

    assign s4_sq_next = 35'(s3_tsh_reg) * 35'(s3_tsh_reg);

    assign sq31 = {s4_sq_reg, 5'd0} - {5'd0, s4_sq_reg};
    assign sq63 = {s4_sq_reg, 6'd0} - {6'd0, s4_sq_reg};

    always_comb
    begin
        s5_temp_next = s4_temp_reg;
        s5_off_next  = s4_off_reg;
        s5_sens_next = s4_sens_reg;
        if (s4_low_reg)
        begin
            s5_temp_next = s4_temp_reg - $signed({2'd0, s4_tcorr_reg});
            s5_off_next  = s4_off_reg - $signed({3'd0, sq31[39:3]});
            s5_sens_next = s4_sens_reg - $signed({2'd0, sq63[40:5]});
        end
    end

    assign s6_ml_next = s5_d1_reg * s5_sens_reg[18:0];
    assign s6_mh_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[37:19]);

    assign s7_prod_next = $signed({s6_mh_reg[43], s6_mh_reg, 19'd0}) +
                          $signed({21'd0, s6_ml_reg});

    assign s8_diff_next = 44'(s7_prod_reg >>> 21) - 44'(s7_off_reg);

    assign pres_wide = 34'(s8_diff_reg >>> 15) + 34'(pressure_bias_reg);

    always_comb
    begin
        result_next.temp_centideg = s8_temp_reg;
        if (pres_wide > $signed({2'b00, 32'h7FFF_FFFF}))
        begin
            result_next.pressure_out = 32'sh7FFF_FFFF;
        end
        else if (pres_wide < $signed({2'b11, 32'h8000_0000}))
        begin
            result_next.pressure_out = 32'sh8000_0000;
        end
        else
        begin
            result_next.pressure_out = 32'(pres_wide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_d1_reg <= sample.raw_pressure;
            s1_dt_reg <= s1_dt_next;
        end
        if (en[1])
        begin
            s2_d1_reg <= s1_d1_reg;
            s2_p6_reg <= s2_p6_next;
            s2_p4_reg <= s2_p4_next;
            s2_p3_reg <= s2_p3_next;
            s2_dd_reg <= s2_dd_next;
        end
        if (en[2])
        begin
            s3_d1_reg    <= s2_d1_reg;
            s3_tsh_reg   <= s3_tsh_next;
            s3_temp_reg  <= s3_temp_next;
            s3_off_reg   <= s3_off_next;
            s3_sens_reg  <= s3_sens_next;
            s3_low_reg   <= s3_tsh_next[18];
            s3_tcorr_reg <= dd11[51:35];
        end
        if (en[3])
        begin
            s4_d1_reg    <= s3_d1_reg;
            s4_temp_reg  <= s3_temp_reg;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_low_reg   <= s3_low_reg;
            s4_tcorr_reg <= s3_tcorr_reg;
            s4_sq_reg    <= s4_sq_next;
        end
        if (en[4])
        begin
            s5_d1_reg   <= s4_d1_reg;
            s5_temp_reg <= s5_temp_next;
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
        end
        if (en[5])
        begin
            s6_temp_reg <= s5_temp_reg;
            s6_off_reg  <= s5_off_reg;
            s6_ml_reg   <= s6_ml_next;
            s6_mh_reg   <= s6_mh_next;
        end
        if (en[6])
        begin
            s7_temp_reg <= s6_temp_reg;
            s7_off_reg  <= s6_off_reg;
            s7_prod_reg <= s7_prod_next;
        end
        if (en[7])
        begin
            s8_temp_reg <= s7_temp_reg;
            s8_diff_reg <= s8_diff_next;
        end
        if (en[8])
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> sv/psc_checker.sv
`timescale 1ns / 1ps

module psc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             sample_valid,
    input logic                             sample_ready,
    input psc_pkg::sample_t                 sample,
    input logic                             result_valid,
    input logic                             result_ready,
    input psc_pkg::result_t                 result,
    input logic                             cfg_write,
    input logic [psc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // a draining output frees the whole pipeline
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("sample_ready low while result_ready high");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("sample_ready low with empty output stage");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.temp_centideg >= -220000) &&
                         (result.temp_centideg <= 134000))
        else $error("compensated temperature out of reach");

endmodule

bind pressure_sensor_compensation_core psc_checker u_psc_checker (.*);

>>> tb/sv/compensation_checker.sv
`timescale 1ns / 1ps

module compensation_checker
    import psc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    input  logic                    sample_ready,
    input  sample_t                 sample,
    input  logic                    result_valid,
    input  logic                    result_ready,
    input  result_t                 result,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      errors,
    output int                      results_seen,
    output int                      outstanding,
    output int                      cold_count
);

    localparam longint PRES_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint PRES_MIN = -64'sh0000_0000_8000_0000;

    logic [15:0]        coeff [0:5];
    logic signed [15:0] bias;
    result_t            expected_readings [$];
    result_t            predicted;
    result_t            want;
    logic               cold;

    function automatic result_t compensate(input sample_t s, output logic is_cold);
        longint  d1;
        longint  d2;
        longint  c1;
        longint  c2;
        longint  c3;
        longint  c4;
        longint  c5;
        longint  c6;
        longint  dt;
        longint  t;
        longint  off;
        longint  sens;
        longint  dev;
        longint  sq;
        longint  p;
        result_t r;
        d1 = {40'd0, s.raw_pressure};
        d2 = {40'd0, s.raw_temp};
        c1 = {48'd0, coeff[CFG_SENS]};
        c2 = {48'd0, coeff[CFG_OFFSET]};
        c3 = {48'd0, coeff[CFG_SENS_TEMP]};
        c4 = {48'd0, coeff[CFG_OFFSET_TEMP]};
        c5 = {48'd0, coeff[CFG_REF_TEMP]};
        c6 = {48'd0, coeff[CFG_TEMP_SLOPE]};
        dt = d2 - c5 * 256;
        t = LOW_TEMP_LIMIT + ((dt * c6) >>> 23);
        off = c2 * 131072 + ((c4 * dt) >>> 6);
        sens = c1 * 65536 + ((c3 * dt) >>> 7);
        is_cold = (t < LOW_TEMP_LIMIT);
        if (is_cold)
        begin
            dev = t - LOW_TEMP_LIMIT;
            sq = dev * dev;
            off = off - ((31 * sq) >>> 3);
            sens = sens - ((63 * sq) >>> 5);
            t = t - ((11 * dt * dt) >>> 35);
        end
        p = ((((d1 * sens) >>> 21) - off) >>> 15) + longint'(bias);
        if (p > PRES_MAX)
        begin
            p = PRES_MAX;
        end
        else if (p < PRES_MIN)
        begin
            p = PRES_MIN;
        end
        r.temp_centideg = t[18:0];
        r.pressure_out = p[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (coeff[i])
            begin
                coeff[i] = '0;
            end
            bias = 16'(BIAS_RESET);
            expected_readings.delete();
            errors = 0;
            results_seen = 0;
            outstanding = 0;
            cold_count = 0;
        end
        else
        begin
            // drop writes to the spare index
            if (cfg_write)
            begin
                if (cfg_index == CFG_BIAS)
                begin
                    bias = cfg_data;
                end
                else if (cfg_index < CFG_BIAS)
                begin
                    coeff[cfg_index] = cfg_data;
                end
            end
            if (sample_valid && sample_ready)
            begin
                predicted = compensate(sample, cold);
                expected_readings.push_back(predicted);
                if (cold)
                begin
                    cold_count++;
                end
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got temp %0d pressure %0d",
                             $time, result.temp_centideg, result.pressure_out);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (result.temp_centideg !== want.temp_centideg)
                    begin
                        errors++;
                        $display("%0t: temp_centideg expected %0d got %0d",
                                 $time, want.temp_centideg, result.temp_centideg);
                    end
                    if (result.pressure_out !== want.pressure_out)
                    begin
                        errors++;
                        $display("%0t: pressure_out expected %0d got %0d",
                                 $time, want.pressure_out, result.pressure_out);
                    end
                end
            end
            outstanding = expected_readings.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import psc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;
    localparam int          MAX_IDLE      = 18;
    localparam int          SETTLE        = 16;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_ITEMS   = 85;
    localparam logic [23:0] RAW_MAX       = 24'hFF_FFFF;

    typedef enum int {PACE_RANDOM, PACE_FULL, PACE_SPARSE} pace_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    sample_t                sample = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int          errors;
    int          results_seen;
    int          outstanding;
    int          cold_count;
    int          sent = 0;
    int          settings = 0;
    int          cycles = 0;
    pace_t       idle_mode = PACE_FULL;
    logic [15:0] cur_ref_temp = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pressure_sensor_compensation_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    compensation_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .results_seen (results_seen),
        .outstanding  (outstanding),
        .cold_count   (cold_count)
    );

    function automatic int draw_idle();
        case (idle_mode)
            PACE_RANDOM: return $urandom_range(0, MAX_IDLE);
            PACE_FULL:   return 0;
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
        endcase
    endfunction

    function automatic logic [15:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] draw_bias();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] draw_raw();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return RAW_MAX;
            default: return 24'($urandom);
        endcase
    endfunction

    // cluster some temperatures around the reference so both sides of 20 C show up
    function automatic logic [23:0] draw_temp_raw();
        int base;
        if ($urandom_range(0, 4) != 0)
        begin
            return draw_raw();
        end
        base = int'(cur_ref_temp) * 256 + int'($urandom_range(0, 64)) - 32;
        if (base < 0)
        begin
            base = 0;
        end
        if (base > int'(RAW_MAX))
        begin
            base = int'(RAW_MAX);
        end
        return 24'(base);
    endfunction

    task automatic send_reading(input logic [23:0] d1, input logic [23:0] d2);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= '{raw_pressure: d1, raw_temp: d2};
        do @(posedge clk); while (!sample_ready);
        sent++;
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        wait (results_seen == sent);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] sens, input logic [15:0] off,
                                input logic [15:0] sens_tc, input logic [15:0] off_tc,
                                input logic [15:0] ref_t, input logic [15:0] slope,
                                input logic [15:0] bias);
        logic [15:0] word [0:7];
        int          i;
        word[CFG_SENS]        = sens;
        word[CFG_OFFSET]      = off;
        word[CFG_SENS_TEMP]   = sens_tc;
        word[CFG_OFFSET_TEMP] = off_tc;
        word[CFG_REF_TEMP]    = ref_t;
        word[CFG_TEMP_SLOPE]  = slope;
        word[CFG_BIAS]        = bias;
        word[CFG_SPARE]       = 16'($urandom);
        for (i = CFG_SENS; i <= CFG_SPARE; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data <= word[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cur_ref_temp = ref_t;
        settings++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: run stalled after %0d cycles", $time, cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = draw_idle();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the calibration words and bias
        send_reading(24'd0, 24'd0);
        send_reading(RAW_MAX, RAW_MAX);
        drain();

        // typical part, warm and cold sides, 20.00 C edge
        idle_mode = PACE_RANDOM;
        program_regs(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146,
                     16'd300);
        send_reading(24'd4958179, 24'd6815414);
        send_reading(24'd4958179, 24'd6821376);
        send_reading(24'd4958179, 24'd6821375);
        send_reading(24'd4958179, 24'd0);
        send_reading(24'd4958179, RAW_MAX);
        send_reading(24'd0, 24'd0);
        send_reading(RAW_MAX, 24'd0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(24'd0, RAW_MAX);
        send_reading(24'h800000, 24'h800000);
        send_reading(24'h555555, 24'hAAAAAA);
        send_reading(24'hAAAAAA, 24'h555555);
        drain();

        // every word at full scale, most negative bias
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
        send_reading(24'd0, 24'd0);
        send_reading(RAW_MAX, 24'd0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(24'd0, RAW_MAX);
        drain();

        // zero reference, most positive bias
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(RAW_MAX, 24'd0);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_mode = pace_t'(phase % 3);
            program_regs(draw_word(), draw_word(), draw_word(), draw_word(), draw_word(),
                         draw_word(), draw_bias());
            repeat (PHASE_ITEMS) send_reading(draw_raw(), draw_temp_raw());
            drain();
        end

        $display("%0d readings compared over %0d register settings, all idle patterns",
                 results_seen, settings);
        $display("%0d of them took the low-temperature correction", cold_count);
        if (outstanding != 0)
        begin
            $display("%0t: %0d expected readings never arrived", $time, outstanding);
        end
        if (errors == 0 && outstanding == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
